// File: src/bmsirq_pkg.sv
// ----------------------------------------------------------------------------
// bmsirq_pkg
// Shared types and constants for the bank mapper with scanline interrupt.
// ----------------------------------------------------------------------------
package bmsirq_pkg;

  localparam int unsigned IRQ_DELAY_TICKS_DEF = 5;
  localparam int unsigned DELAY_W = 3;

  localparam int unsigned ADDR_W = 19;
  localparam int unsigned PRG_BANK_W = 6;
  localparam int unsigned CHR_BANK_W = 8;
  localparam int unsigned PRG_COUNT_W = 7;

  typedef enum logic [2:0] {
    OP_CPU_WRITE = 3'd0,
    OP_CPU_READ  = 3'd1,
    OP_PPU_READ  = 3'd2,
    OP_PPU_WRITE = 3'd3,
    OP_CPU_TICK  = 3'd4
  } opcode_t;

  // CPU register decode, bus_address AND REG_DECODE_MASK
  localparam logic [15:0] REG_DECODE_MASK = 16'hE003;
  localparam logic [15:0] REG_PRG0        = 16'h8000;
  localparam logic [15:0] REG_PRG1        = 16'h8001;
  localparam logic [15:0] REG_CHR_WIDE0   = 16'h8002;
  localparam logic [15:0] REG_CHR_WIDE1   = 16'h8003;
  localparam logic [15:0] REG_CHR_NARROW0 = 16'hA000;
  localparam logic [15:0] REG_CHR_NARROW1 = 16'hA001;
  localparam logic [15:0] REG_CHR_NARROW2 = 16'hA002;
  localparam logic [15:0] REG_CHR_NARROW3 = 16'hA003;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC000;
  localparam logic [15:0] REG_IRQ_CLEAR   = 16'hC001;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hC002;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hC003;
  localparam logic [15:0] REG_MIRROR      = 16'hE000;

  localparam int unsigned MIRROR_BIT = 6;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRG_BANK_COUNT   = 2'd0,
    CFG_CHR_ADDRESS_MASK = 2'd1,
    CFG_CHR_IS_RAM       = 2'd2,
    CFG_FOUR_SCREEN      = 2'd3
  } cfg_index_t;

  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RST = 7'd2;
  localparam logic [ADDR_W-1:0]      CHR_MASK_RST  = 19'h01FFF;

  typedef struct packed {
    logic       a12_clock;
    logic       a12;
    logic       tick;
    logic       reload_wr;
    logic       clear_wr;
    logic       enable_wr;
    logic       disable_wr;
    logic [7:0] data;
  } irq_cmd_t;

endpackage

// File: src/bank_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// Cartridge bank mapper: register writes, address translation and scanline
// interrupt, one transaction in and one result transaction out per item.
//
// Channel  Dir  Transaction
// s_*      in   opcode in tuser, bus_address and write_data in tdata
// m_*      out  mapped address, flags, irq and mirroring in tdata
// apb      in   configuration registers at 0x0, 0x4, 0x8, 0xC
//
// One item per cycle; the result appears in the cycle after acceptance.
// The result is registered; s_tready holds low only while a
// result waits and m_tready is low. Synchronous reset sets all mapper
// state and configuration to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq #(
  parameter int unsigned IRQ_DELAY_TICKS = bmsirq_pkg::IRQ_DELAY_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_data
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [18:0] mapped_address, [19] address_valid,
                                 // [20] chr_write_enable, [21] irq_line,
                                 // [22] horizontal_mirroring, [23] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = bmsirq_pkg::ADDR_W;

  logic [bmsirq_pkg::PRG_COUNT_W-1:0] prg_bank_count;
  logic [AW-1:0]                      chr_address_mask;
  logic                               chr_is_ram;
  logic                               four_screen;

  logic [bmsirq_pkg::PRG_BANK_W-1:0]  prg_bank [2];
  logic [bmsirq_pkg::CHR_BANK_W-1:0]  chr_wide [2];
  logic [bmsirq_pkg::CHR_BANK_W-1:0]  chr_narrow [4];
  logic                               mirror_horizontal, mirror_horizontal_next;

  logic                               accept;
  logic                               cfg_write;
  bmsirq_pkg::cfg_index_t             cfg_index;
  bmsirq_pkg::opcode_t                opcode;
  logic [15:0]                        bus_address;
  logic [7:0]                         write_data;
  logic [15:0]                        reg_key;
  logic                               ppu_in_range;
  logic [AW-1:0]                      cpu_address;
  logic [AW-1:0]                      ppu_address;
  logic [AW-1:0]                      mapped_next;
  logic                               valid_next;
  logic                               wen_next;
  logic                               pending_next;
  bmsirq_pkg::irq_cmd_t               cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = bmsirq_pkg::cfg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count   <= bmsirq_pkg::PRG_COUNT_RST;
      chr_address_mask <= bmsirq_pkg::CHR_MASK_RST;
      chr_is_ram       <= 1'b1;
      four_screen      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmsirq_pkg::CFG_PRG_BANK_COUNT:   prg_bank_count   <= pwdata[6:0];
        bmsirq_pkg::CFG_CHR_ADDRESS_MASK: chr_address_mask <= pwdata[AW-1:0];
        bmsirq_pkg::CFG_CHR_IS_RAM:       chr_is_ram       <= pwdata[0];
        bmsirq_pkg::CFG_FOUR_SCREEN:      four_screen      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      bmsirq_pkg::CFG_PRG_BANK_COUNT:   prdata = {25'd0, prg_bank_count};
      bmsirq_pkg::CFG_CHR_ADDRESS_MASK: prdata = {13'd0, chr_address_mask};
      bmsirq_pkg::CFG_CHR_IS_RAM:       prdata = {31'd0, chr_is_ram};
      bmsirq_pkg::CFG_FOUR_SCREEN:      prdata = {31'd0, four_screen};
      default:                          prdata = 32'd0;
    endcase
  end

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign opcode      = bmsirq_pkg::opcode_t'(s_tuser);
  assign bus_address = s_tdata[15:0];
  assign write_data  = s_tdata[23:16];
  assign reg_key     = bus_address & bmsirq_pkg::REG_DECODE_MASK;
  assign ppu_in_range = (bus_address[15:13] == 3'd0);

  bmsirq_xlate u_xlate (
    .bus_address      (bus_address),
    .prg_bank0        (prg_bank[0]),
    .prg_bank1        (prg_bank[1]),
    .prg_bank_count   (prg_bank_count),
    .chr_wide0        (chr_wide[0]),
    .chr_wide1        (chr_wide[1]),
    .chr_narrow0      (chr_narrow[0]),
    .chr_narrow1      (chr_narrow[1]),
    .chr_narrow2      (chr_narrow[2]),
    .chr_narrow3      (chr_narrow[3]),
    .chr_address_mask (chr_address_mask),
    .cpu_address      (cpu_address),
    .ppu_address      (ppu_address)
  );

  // Result fields and interrupt commands for the current item
  always_comb begin
    mapped_next            = '0;
    valid_next             = 1'b0;
    wen_next               = 1'b0;
    mirror_horizontal_next = mirror_horizontal;
    cmd                    = '0;
    cmd.data               = write_data;
    cmd.a12                = bus_address[12];
    case (opcode)
      bmsirq_pkg::OP_CPU_WRITE: begin
        unique case (reg_key)
          bmsirq_pkg::REG_IRQ_RELOAD:  cmd.reload_wr  = accept;
          bmsirq_pkg::REG_IRQ_CLEAR:   cmd.clear_wr   = accept;
          bmsirq_pkg::REG_IRQ_ENABLE:  cmd.enable_wr  = accept;
          bmsirq_pkg::REG_IRQ_DISABLE: cmd.disable_wr = accept;
          bmsirq_pkg::REG_MIRROR: begin
            if (!four_screen) begin
              mirror_horizontal_next = write_data[bmsirq_pkg::MIRROR_BIT];
            end
          end
          default: ;
        endcase
      end
      bmsirq_pkg::OP_CPU_READ: begin
        if (bus_address[15]) begin
          mapped_next = cpu_address;
          valid_next  = 1'b1;
        end
      end
      bmsirq_pkg::OP_PPU_READ: begin
        if (ppu_in_range) begin
          mapped_next   = ppu_address;
          valid_next    = 1'b1;
          cmd.a12_clock = accept;
        end
      end
      bmsirq_pkg::OP_PPU_WRITE: begin
        if (ppu_in_range) begin
          if (chr_is_ram) begin
            mapped_next = ppu_address;
            valid_next  = 1'b1;
            wen_next    = 1'b1;
          end
          cmd.a12_clock = accept;
        end
      end
      bmsirq_pkg::OP_CPU_TICK: cmd.tick = accept;
      default: ;
    endcase
  end

  bmsirq_irq #(
    .IRQ_DELAY_TICKS (IRQ_DELAY_TICKS)
  ) u_irq (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pending_next (pending_next)
  );

  // Bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank[0]       <= '0;
      prg_bank[1]       <= '0;
      chr_wide[0]       <= '0;
      chr_wide[1]       <= '0;
      chr_narrow[0]     <= '0;
      chr_narrow[1]     <= '0;
      chr_narrow[2]     <= '0;
      chr_narrow[3]     <= '0;
      mirror_horizontal <= 1'b0;
    end else if (accept) begin
      mirror_horizontal <= mirror_horizontal_next;
      if (opcode == bmsirq_pkg::OP_CPU_WRITE) begin
        unique case (reg_key)
          bmsirq_pkg::REG_PRG0:        prg_bank[0]   <= write_data[5:0];
          bmsirq_pkg::REG_PRG1:        prg_bank[1]   <= write_data[5:0];
          bmsirq_pkg::REG_CHR_WIDE0:   chr_wide[0]   <= write_data;
          bmsirq_pkg::REG_CHR_WIDE1:   chr_wide[1]   <= write_data;
          bmsirq_pkg::REG_CHR_NARROW0: chr_narrow[0] <= write_data;
          bmsirq_pkg::REG_CHR_NARROW1: chr_narrow[1] <= write_data;
          bmsirq_pkg::REG_CHR_NARROW2: chr_narrow[2] <= write_data;
          bmsirq_pkg::REG_CHR_NARROW3: chr_narrow[3] <= write_data;
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, mirror_horizontal_next, pending_next, wen_next, valid_next,
                  mapped_next};
    end
  end

endmodule

// File: src/bmsirq_xlate.sv
// ----------------------------------------------------------------------------
// bmsirq_xlate
// Translates CPU and PPU bus addresses to physical program and character
// memory byte addresses from the current bank registers.
// ----------------------------------------------------------------------------
module bmsirq_xlate (
  input  logic [15:0]                          bus_address,
  input  logic [bmsirq_pkg::PRG_BANK_W-1:0]    prg_bank0,
  input  logic [bmsirq_pkg::PRG_BANK_W-1:0]    prg_bank1,
  input  logic [bmsirq_pkg::PRG_COUNT_W-1:0]   prg_bank_count,
  input  logic [bmsirq_pkg::CHR_BANK_W-1:0]    chr_wide0,
  input  logic [bmsirq_pkg::CHR_BANK_W-1:0]    chr_wide1,
  input  logic [bmsirq_pkg::CHR_BANK_W-1:0]    chr_narrow0,
  input  logic [bmsirq_pkg::CHR_BANK_W-1:0]    chr_narrow1,
  input  logic [bmsirq_pkg::CHR_BANK_W-1:0]    chr_narrow2,
  input  logic [bmsirq_pkg::CHR_BANK_W-1:0]    chr_narrow3,
  input  logic [bmsirq_pkg::ADDR_W-1:0]        chr_address_mask,
  output logic [bmsirq_pkg::ADDR_W-1:0]        cpu_address,
  output logic [bmsirq_pkg::ADDR_W-1:0]        ppu_address
);

  logic [bmsirq_pkg::PRG_COUNT_W-1:0] fixed_second;
  logic [bmsirq_pkg::PRG_COUNT_W-1:0] fixed_last;
  logic [bmsirq_pkg::PRG_BANK_W-1:0]  prg_bank;
  logic [bmsirq_pkg::CHR_BANK_W-1:0]  wide_bank;
  logic [bmsirq_pkg::CHR_BANK_W-1:0]  narrow_bank;
  logic [bmsirq_pkg::ADDR_W-1:0]      chr_base;
  logic [bmsirq_pkg::ADDR_W-1:0]      chr_offset;

  assign fixed_second = prg_bank_count - 7'd2;
  assign fixed_last   = prg_bank_count - 7'd1;

  always_comb begin
    case (bus_address[14:13])
      2'd0:    prg_bank = prg_bank0;
      2'd1:    prg_bank = prg_bank1;
      2'd2:    prg_bank = fixed_second[bmsirq_pkg::PRG_BANK_W-1:0];
      default: prg_bank = fixed_last[bmsirq_pkg::PRG_BANK_W-1:0];
    endcase
  end

  assign cpu_address = {prg_bank, bus_address[12:0]};

  assign wide_bank = bus_address[11] ? chr_wide1 : chr_wide0;

  always_comb begin
    case (bus_address[11:10])
      2'd0:    narrow_bank = chr_narrow0;
      2'd1:    narrow_bank = chr_narrow1;
      2'd2:    narrow_bank = chr_narrow2;
      default: narrow_bank = chr_narrow3;
    endcase
  end

  always_comb begin
    if (!bus_address[12]) begin
      chr_base   = {wide_bank, 11'd0} & chr_address_mask;
      chr_offset = {8'd0, bus_address[10:0]};
    end else begin
      chr_base   = {1'b0, narrow_bank, 10'd0} & chr_address_mask;
      chr_offset = {9'd0, bus_address[9:0]};
    end
  end

  assign ppu_address = chr_base + chr_offset;

endmodule

// File: src/bmsirq_irq.sv
// ----------------------------------------------------------------------------
// bmsirq_irq
// Scanline counter clocked by rising PPU A12, delay countdown on CPU ticks
// and the interrupt pending flag.
// ----------------------------------------------------------------------------
module bmsirq_irq #(
  parameter int unsigned IRQ_DELAY_TICKS = bmsirq_pkg::IRQ_DELAY_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bmsirq_pkg::irq_cmd_t  cmd,
  output logic                  pending_next
);

  logic [7:0]                         counter, counter_next;
  logic [7:0]                         reload, reload_next;
  logic                               enabled, enabled_next;
  logic [bmsirq_pkg::DELAY_W-1:0]     delay, delay_next;
  logic                               prev_a12, prev_a12_next;
  logic                               pending;
  logic [7:0]                         counter_step;

  assign counter_step = (counter == 8'd0) ? reload : counter - 8'd1;

  always_comb begin
    counter_next  = counter;
    reload_next   = reload;
    enabled_next  = enabled;
    delay_next    = delay;
    prev_a12_next = prev_a12;
    pending_next  = pending;
    if (cmd.a12_clock) begin
      prev_a12_next = cmd.a12;
      if (cmd.a12 && !prev_a12) begin
        counter_next = counter_step;
        if (counter_step == 8'd0 && delay == '0 && enabled) begin
          delay_next   = IRQ_DELAY_TICKS[bmsirq_pkg::DELAY_W-1:0];
          enabled_next = 1'b0;
        end
      end
    end
    if (cmd.tick) begin
      if (delay == 3'd1) begin
        pending_next = 1'b1;
        delay_next   = '0;
        enabled_next = 1'b0;
      end else if (delay > 3'd1) begin
        delay_next = delay - 3'd1;
      end
    end
    if (cmd.reload_wr) begin
      reload_next = ~cmd.data;
    end
    if (cmd.clear_wr) begin
      counter_next = 8'd0;
    end
    if (cmd.enable_wr) begin
      enabled_next = 1'b1;
    end
    if (cmd.disable_wr) begin
      enabled_next = 1'b0;
      delay_next   = '0;
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= 8'd0;
      reload   <= 8'hFF;
      enabled  <= 1'b0;
      delay    <= '0;
      prev_a12 <= 1'b0;
      pending  <= 1'b0;
    end else begin
      counter  <= counter_next;
      reload   <= reload_next;
      enabled  <= enabled_next;
      delay    <= delay_next;
      prev_a12 <= prev_a12_next;
      pending  <= pending_next;
    end
  end

endmodule

// File: dv/tb_bank_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// tb_bank_mapper_with_scanline_irq
// Self-checking testbench for the bank mapper with scanline interrupt. A short
// table of directed transactions runs first, then random traffic in phases,
// each under its own register setting, with scanline bursts that arm and
// raise the interrupt. Every result is checked field by field, against fixed
// values for typed directed rows, else a behavioral mapper model in this file.
// ----------------------------------------------------------------------------
module tb_bank_mapper_with_scanline_irq;
  import bmsirq_pkg::*;

  localparam int unsigned IRQ_DELAY_TICKS = IRQ_DELAY_TICKS_DEF;
  localparam logic [2:0]  OP_UNUSED_LO    = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI    = 3'd7;
  localparam int          PHASES          = 6;
  localparam int          PHASE_ITEMS     = 122;
  localparam int          LONG_HOLD       = 300;
  localparam int          DRAIN_CYCLES    = 4;

  typedef struct packed {
    logic        hmirror;
    logic        irq;
    logic        wen;
    logic        valid;
    logic [18:0] maddr;
  } mapper_result_t;

  typedef struct packed {
    logic [2:0]     op;
    logic [15:0]    addr;
    logic [7:0]     data;
    logic           typed;
    mapper_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [15:0] bus_address, [23:16] write_data
  logic [2:0]  s_tuser;   // [2:0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [18:0] mapped_address, [19] address_valid,
                          // [20] chr_write_enable, [21] irq_line,
                          // [22] horizontal_mirroring, [23] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bank_mapper_with_scanline_irq uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mapper model state
  logic [5:0]  prg_sel [2];
  logic [7:0]  chr_2k [4];
  logic [7:0]  chr_1k [4];
  logic [7:0]  scan_count;
  logic [7:0]  scan_reload;
  logic        scan_armed;
  logic [2:0]  irq_wait;
  logic        a12_last;
  logic        irq_raised;
  logic        mirror_h;
  logic [6:0]  prg_banks;
  logic [18:0] chr_mask;
  logic        chr_ram;
  logic        four_scr;

  mapper_result_t pending_results [$];
  stim_row_t      directed_rows [$];
  int             mismatches = 0;
  int             results_checked = 0;
  int             items_sent = 0;
  int             irqs_predicted = 0;
  bit             idle_on = 1'b0;
  bit             rx_hold_req = 1'b0;
  bit             hold_done = 1'b0;
  logic [23:0]    got;
  mapper_result_t want;

  function automatic mapper_result_t exp_res(input logic [18:0] maddr, input logic valid,
                                             input logic wen, input logic irq,
                                             input logic hmirror);
    mapper_result_t r;
    r.maddr = maddr;
    r.valid = valid;
    r.wen = wen;
    r.irq = irq;
    r.hmirror = hmirror;
    return r;
  endfunction

  function automatic mapper_result_t predict_mapping(input logic [2:0] op,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data);
    mapper_result_t r;
    logic [31:0]    bank;
    logic [18:0]    base;
    logic [18:0]    off;
    r = '0;
    case (op)
      OP_CPU_WRITE: begin
        case (addr & REG_DECODE_MASK)
          REG_PRG0:        prg_sel[0] = data[5:0];
          REG_PRG1:        prg_sel[1] = data[5:0];
          REG_CHR_WIDE0:   chr_2k[0] = data;
          REG_CHR_WIDE1:   chr_2k[1] = data;
          REG_CHR_NARROW0: chr_1k[0] = data;
          REG_CHR_NARROW1: chr_1k[1] = data;
          REG_CHR_NARROW2: chr_1k[2] = data;
          REG_CHR_NARROW3: chr_1k[3] = data;
          REG_IRQ_RELOAD:  scan_reload = ~data;
          REG_IRQ_CLEAR:   scan_count = 8'd0;
          REG_IRQ_ENABLE:  scan_armed = 1'b1;
          REG_IRQ_DISABLE: begin
            scan_armed = 1'b0;
            irq_wait = 3'd0;
            irq_raised = 1'b0;
          end
          REG_MIRROR: begin
            if (!four_scr) mirror_h = data[MIRROR_BIT];
          end
          default: ;
        endcase
      end
      OP_CPU_READ: begin
        if (addr[15]) begin
          case (addr[14:13])
            2'd0:    bank = 32'(prg_sel[0]);
            2'd1:    bank = 32'(prg_sel[1]);
            2'd2:    bank = 32'(prg_banks) - 32'd2;
            default: bank = 32'(prg_banks) - 32'd1;
          endcase
          r.maddr = 19'((bank << 13) + 32'(addr[12:0]));
          r.valid = 1'b1;
        end
      end
      OP_PPU_READ, OP_PPU_WRITE: begin
        if (addr < 16'h2000) begin
          if (!addr[12]) begin
            base = {chr_2k[{1'b0, addr[11]}], 11'b0} & chr_mask;
            off = 19'(addr[10:0]);
          end else begin
            base = {1'b0, chr_1k[addr[11:10]], 10'b0} & chr_mask;
            off = 19'(addr[9:0]);
          end
          if (op == OP_PPU_READ || chr_ram) begin
            r.maddr = base + off;
            r.valid = 1'b1;
            r.wen = (op == OP_PPU_WRITE);
          end
          if (addr[12] && !a12_last) begin
            scan_count = (scan_count == 8'd0) ? scan_reload : scan_count - 8'd1;
            if (scan_count == 8'd0 && irq_wait == 3'd0 && scan_armed) begin
              irq_wait = 3'(IRQ_DELAY_TICKS);
              scan_armed = 1'b0;
            end
          end
          a12_last = addr[12];
        end
      end
      OP_CPU_TICK: begin
        if (irq_wait == 3'd1) begin
          irq_raised = 1'b1;
          irq_wait = 3'd0;
          scan_armed = 1'b0;
          irqs_predicted++;
        end else if (irq_wait > 3'd1) begin
          irq_wait = irq_wait - 3'd1;
        end
      end
      default: ;
    endcase
    r.irq = irq_raised;
    r.hmirror = mirror_h;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 6) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] reg_addr(input logic [15:0] reg_base);
    return (16'($urandom) & ~REG_DECODE_MASK) | reg_base;
  endfunction

  function automatic logic [15:0] reg_by_slot(input int slot);
    case (slot)
      0:  return REG_PRG0;
      1:  return REG_PRG1;
      2:  return REG_CHR_WIDE0;
      3:  return REG_CHR_WIDE1;
      4:  return REG_CHR_NARROW0;
      5:  return REG_CHR_NARROW1;
      6:  return REG_CHR_NARROW2;
      7:  return REG_CHR_NARROW3;
      8:  return REG_IRQ_RELOAD;
      9:  return REG_IRQ_CLEAR;
      10: return REG_IRQ_ENABLE;
      11: return REG_IRQ_DISABLE;
      default: return REG_MIRROR;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] wanted);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
             results_checked, what, seen, wanted);
    mismatches++;
  endtask

  task automatic send_item(input logic [2:0] op, input logic [15:0] addr,
                           input logic [7:0] data, input logic typed,
                           input mapper_result_t typed_want);
    mapper_result_t r;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {data, addr};
    do @(posedge clk); while (!s_tready);
    r = predict_mapping(op, addr, data);
    pending_results.push_back(typed ? typed_want : r);
    items_sent++;
  endtask

  task automatic send_plain(input logic [2:0] op, input logic [15:0] addr,
                            input logic [7:0] data);
    send_item(op, addr, data, 1'b0, '0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      CFG_PRG_BANK_COUNT:   prg_banks = val[6:0];
      CFG_CHR_ADDRESS_MASK: chr_mask = val[18:0];
      CFG_CHR_IS_RAM:       chr_ram = val[0];
      CFG_FOUR_SCREEN:      four_scr = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic random_item();
    int          pick;
    logic [2:0]  op;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    if (pick < 30) begin
      op = $urandom_range(0, 1) ? OP_PPU_READ : OP_PPU_WRITE;
      a[15:13] = 3'b000;
    end else if (pick < 45) begin
      op = OP_CPU_READ;
      if ($urandom_range(0, 7) != 0) a[15] = 1'b1;
    end else if (pick < 65) begin
      op = OP_CPU_WRITE;
      a = reg_addr(reg_by_slot($urandom_range(0, 12)));
      if ((a & REG_DECODE_MASK) == REG_IRQ_RELOAD && $urandom_range(0, 3) != 0)
        d = ~8'($urandom_range(0, 6));
    end else if (pick < 80) begin
      op = OP_CPU_TICK;
    end else begin
      case ($urandom_range(0, 2))
        0: op = OP_CPU_WRITE;
        1: begin
          op = $urandom_range(0, 1) ? OP_PPU_READ : OP_PPU_WRITE;
          a[15:13] = 3'($urandom_range(1, 7));
        end
        default: op = OP_UNUSED_LO + 3'($urandom_range(0, 2));
      endcase
    end
    send_plain(op, a, d);
  endtask

  task automatic scanline_burst();
    int         lines;
    logic [7:0] reload;
    logic [2:0] op;
    reload = 8'($urandom_range(0, 5));
    send_plain(OP_CPU_WRITE, reg_addr(REG_IRQ_RELOAD), ~reload);
    if ($urandom_range(0, 1)) send_plain(OP_CPU_WRITE, reg_addr(REG_IRQ_CLEAR), 8'($urandom));
    send_plain(OP_CPU_WRITE, reg_addr(REG_IRQ_ENABLE), 8'($urandom));
    lines = $urandom_range(1, int'(reload) + 3);
    repeat (lines) begin
      op = $urandom_range(0, 1) ? OP_PPU_READ : OP_PPU_WRITE;
      send_plain(op, {4'b0000, 12'($urandom)}, 8'($urandom));
      send_plain(op, {4'b0001, 12'($urandom)}, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send_plain(OP_CPU_TICK, 16'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(3, 7)) send_plain(OP_CPU_TICK, 16'($urandom), 8'($urandom));
    if ($urandom_range(0, 2) != 0)
      send_plain(OP_CPU_WRITE, reg_addr(REG_IRQ_DISABLE), 8'($urandom));
  endtask

  // result receiver
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (!idle_on || $urandom_range(0, 3) != 0) begin
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b0;
        n = gap_len();
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got[18:0] !== want.maddr) flag_mismatch("mapped_address", 32'(got[18:0]), 32'(want.maddr));
        if (got[19] !== want.valid)   flag_mismatch("address_valid", 32'(got[19]), 32'(want.valid));
        if (got[20] !== want.wen)     flag_mismatch("chr_write_enable", 32'(got[20]), 32'(want.wen));
        if (got[21] !== want.irq)     flag_mismatch("irq_line", 32'(got[21]), 32'(want.irq));
        if (got[22] !== want.hmirror) flag_mismatch("horizontal_mirroring", 32'(got[22]),
                                                    32'(want.hmirror));
        if (got[23] !== 1'b0)         flag_mismatch("pad bit", 32'(got[23]), 32'd0);
      end
      results_checked++;
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase_items;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_CPU_TICK;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < 2; i++) prg_sel[i] = '0;
    for (int i = 0; i < 4; i++) begin
      chr_2k[i] = '0;
      chr_1k[i] = '0;
    end
    scan_count = 8'd0;
    scan_reload = 8'hFF;
    scan_armed = 1'b0;
    irq_wait = 3'd0;
    a12_last = 1'b0;
    irq_raised = 1'b0;
    mirror_h = 1'b0;
    prg_banks = PRG_COUNT_RST;
    chr_mask = CHR_MASK_RST;
    chr_ram = 1'b1;
    four_scr = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset register setting: 2 program banks, 8 KiB character RAM
    directed_rows.push_back({OP_CPU_READ, 16'h8000, 8'h00, 1'b1,
                             exp_res(19'h0, 1'b1, 1'b0, 1'b0, 1'b0)});
    directed_rows.push_back({OP_CPU_READ, 16'hFFFF, 8'hFF, 1'b1,
                             exp_res(19'h03FFF, 1'b1, 1'b0, 1'b0, 1'b0)});
    directed_rows.push_back({OP_CPU_READ, 16'h7FFF, 8'h00, 1'b1,
                             exp_res(19'h0, 1'b0, 1'b0, 1'b0, 1'b0)});
    directed_rows.push_back({OP_PPU_WRITE, 16'h1FFF, 8'hFF, 1'b1,
                             exp_res(19'h003FF, 1'b1, 1'b1, 1'b0, 1'b0)});
    directed_rows.push_back({OP_PPU_READ, 16'hFFFF, 8'hFF, 1'b1,
                             exp_res(19'h0, 1'b0, 1'b0, 1'b0, 1'b0)});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_MIRROR, 8'hFF, 1'b1,
                             exp_res(19'h0, 1'b0, 1'b0, 1'b0, 1'b1)});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_PRG0, 8'hFF, 1'b1,
                             exp_res(19'h0, 1'b0, 1'b0, 1'b0, 1'b1)});
    directed_rows.push_back({OP_CPU_READ, 16'h9FFF, 8'h00, 1'b1,
                             exp_res(19'h7FFFF, 1'b1, 1'b0, 1'b0, 1'b1)});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_CHR_WIDE1, 8'hFF, 1'b0, 23'h0});
    directed_rows.push_back({OP_PPU_READ, 16'h0FFF, 8'h00, 1'b0, 23'h0});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_MIRROR | 16'h0003, 8'h00, 1'b0, 23'h0});
    directed_rows.push_back({OP_UNUSED_HI, 16'hFFFF, 8'hFF, 1'b0, 23'h0});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_IRQ_RELOAD, 8'hFE, 1'b0, 23'h0});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_IRQ_CLEAR, 8'h00, 1'b0, 23'h0});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_IRQ_ENABLE, 8'h00, 1'b0, 23'h0});
    directed_rows.push_back({OP_PPU_READ, 16'h1000, 8'h00, 1'b0, 23'h0});
    directed_rows.push_back({OP_PPU_READ, 16'h0000, 8'h00, 1'b0, 23'h0});
    directed_rows.push_back({OP_PPU_READ, 16'h1400, 8'h00, 1'b0, 23'h0});
    repeat (5) directed_rows.push_back({OP_CPU_TICK, 16'hFFFF, 8'hFF, 1'b0, 23'h0});
    directed_rows.push_back({3'(OP_CPU_WRITE), REG_IRQ_DISABLE, 8'h00, 1'b0, 23'h0});
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].want);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_PRG_BANK_COUNT, 32'd64);
          cfg_write(CFG_CHR_ADDRESS_MASK, 32'h7FFFF);
          cfg_write(CFG_CHR_IS_RAM, 32'd1);
          cfg_write(CFG_FOUR_SCREEN, 32'd0);
        end
        1: begin
          cfg_write(CFG_PRG_BANK_COUNT, 32'd2);
          cfg_write(CFG_CHR_ADDRESS_MASK, 32'h0);
          cfg_write(CFG_CHR_IS_RAM, 32'd0);
          cfg_write(CFG_FOUR_SCREEN, 32'd1);
        end
        2: begin
          cfg_write(CFG_PRG_BANK_COUNT, 32'd33);
          cfg_write(CFG_CHR_ADDRESS_MASK, 32'($urandom_range(0, 32'h7FFFF)));
          cfg_write(CFG_CHR_IS_RAM, 32'd1);
          cfg_write(CFG_FOUR_SCREEN, 32'd1);
        end
        3: begin
          cfg_write(CFG_PRG_BANK_COUNT, 32'd3);
          cfg_write(CFG_CHR_ADDRESS_MASK, 32'($urandom_range(0, 32'h7FFFF)));
          cfg_write(CFG_CHR_IS_RAM, 32'd0);
          cfg_write(CFG_FOUR_SCREEN, 32'd0);
        end
        4: begin
          cfg_write(CFG_PRG_BANK_COUNT, 32'($urandom_range(2, 64)));
          cfg_write(CFG_CHR_ADDRESS_MASK, 32'h7FFFF);
          cfg_write(CFG_CHR_IS_RAM, 32'd1);
          cfg_write(CFG_FOUR_SCREEN, 32'd0);
        end
        default: begin
          cfg_write(CFG_PRG_BANK_COUNT, 32'd64);
          cfg_write(CFG_CHR_ADDRESS_MASK, 32'h01FFF);
          cfg_write(CFG_CHR_IS_RAM, 32'd0);
          cfg_write(CFG_FOUR_SCREEN, 32'd1);
        end
      endcase
      idle_on = (ph != 0);
      phase_items = items_sent + PHASE_ITEMS;
      while (items_sent < phase_items) begin
        // stall the result side while transactions keep coming
        if (ph == 2 && !hold_done && items_sent >= phase_items - PHASE_ITEMS / 2) begin
          rx_hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) scanline_burst();
        else random_item();
      end
      wait_idle();
    end

    $display("Summary: %0d transactions sent (%0d directed), %0d results checked",
             items_sent, directed_rows.size(), results_checked);
    $display("Summary: %0d register settings incl. extremes, %0d interrupts raised",
             PHASES + 1, irqs_predicted);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
